>>> design/external_interrupt_sense_unit_top_macros.svh
// assertion macros for the external interrupt sense unit
// used by modules that check their own control logic; expects clk and rst in scope
`ifndef EXTERNAL_INTERRUPT_SENSE_UNIT_TOP_MACROS_SVH
`define EXTERNAL_INTERRUPT_SENSE_UNIT_TOP_MACROS_SVH

// same-cycle implication
`define EISU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define EISU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/eisu_pkg.sv
// shared types and codes for the external interrupt sense unit
// no dependencies
`default_nettype none

package eisu_pkg;

  localparam logic [2:0] REQ_READ    = 3'd0;
  localparam logic [2:0] REQ_WRITE   = 3'd1;
  localparam logic [2:0] REQ_PIN     = 3'd2;
  localparam logic [2:0] REQ_TICK    = 3'd3;
  localparam logic [2:0] REQ_CONSUME = 3'd4;

  localparam logic [1:0] SEL_SENSE_LOW  = 2'd0;
  localparam logic [1:0] SEL_SENSE_HIGH = 2'd1;
  localparam logic [1:0] SEL_MASK       = 2'd2;
  localparam logic [1:0] SEL_FLAGS      = 2'd3;

  localparam logic [1:0] MODE_LOW  = 2'h0;
  localparam logic [1:0] MODE_ANY  = 2'h1;
  localparam logic [1:0] MODE_FALL = 2'h2;
  localparam logic [1:0] MODE_RISE = 2'h3;

  typedef enum logic {
    ST_EMPTY,
    ST_FULL
  } state_t;

  typedef struct packed {
    logic load;
  } cmd_t;

endpackage

`default_nettype wire

>>> design/eisu_datapath.sv
// register file, sense logic and result register of the interrupt sense unit
// depends on eisu_pkg; driven by eisu_ctrl through eisu_pkg::cmd_t
`default_nettype none

module eisu_datapath #(
  parameter int LINES = 8
) (
  input  wire              clk,
  input  wire              rst,
  input  eisu_pkg::cmd_t   cmd,
  input  wire  [2:0]       req_type,
  input  wire  [1:0]       reg_sel,
  input  wire  [7:0]       wdata,
  input  wire  [2:0]       line_index,
  input  wire              pin_level,
  output logic [7:0]       rdata,
  output logic             irq_pending,
  output logic [2:0]       irq_line,
  output logic             consumed,
  output logic [2:0]       taken_line,
  output logic             adc_trigger
);

  logic [7:0] sense_ctrl_low, sense_ctrl_low_next;
  logic [7:0] sense_ctrl_high, sense_ctrl_high_next;
  logic [7:0] line_mask, line_mask_next;
  logic [7:0] line_flags, line_flags_next;
  logic [7:0] line_levels, line_levels_next;

  logic [7:0]  line_en;
  logic [15:0] modes;
  logic [7:0]  raise;
  logic [7:0]  take;
  logic [7:0]  rdata_next;
  logic        found_c, found_p;
  logic [2:0]  idx_c, idx_p;
  logic        pin_ok, prev;

  // lowest set bit
  function automatic logic [3:0] lowest(input logic [7:0] v);
    logic [3:0] r;
    r = 4'd0;
    for (int i = 7; i >= 0; i--) begin
      if (v[i]) r = {1'b1, 3'(i)};
    end
    return r;
  endfunction

  always_comb begin
    for (int i = 0; i < 8; i++) line_en[i] = (i < LINES);
  end

  assign modes  = {sense_ctrl_high, sense_ctrl_low};
  assign pin_ok = ({1'b0, line_index} < 4'(LINES));
  assign prev   = line_levels[line_index];

  always_comb begin
    sense_ctrl_low_next  = sense_ctrl_low;
    sense_ctrl_high_next = sense_ctrl_high;
    line_mask_next       = line_mask;
    line_levels_next     = line_levels;
    raise                = 8'd0;
    take                 = 8'd0;
    rdata_next           = 8'd0;
    {found_c, idx_c}     = lowest(line_flags & line_mask & line_en);
    case (req_type)
      eisu_pkg::REQ_READ: begin
        case (reg_sel)
          eisu_pkg::SEL_SENSE_LOW:  rdata_next = sense_ctrl_low;
          eisu_pkg::SEL_SENSE_HIGH: rdata_next = sense_ctrl_high;
          eisu_pkg::SEL_MASK:       rdata_next = line_mask;
          default:                  rdata_next = line_flags;
        endcase
      end
      eisu_pkg::REQ_WRITE: begin
        case (reg_sel)
          eisu_pkg::SEL_SENSE_LOW:  sense_ctrl_low_next  = wdata;
          eisu_pkg::SEL_SENSE_HIGH: sense_ctrl_high_next = wdata;
          eisu_pkg::SEL_MASK:       line_mask_next       = wdata;
          default:                  take                 = wdata;
        endcase
      end
      eisu_pkg::REQ_PIN: begin
        if (pin_ok) begin
          line_levels_next[line_index] = pin_level;
          case (modes[{line_index, 1'b0} +: 2])
            eisu_pkg::MODE_LOW:  raise[line_index] = !pin_level;
            eisu_pkg::MODE_ANY:  raise[line_index] = (prev != pin_level);
            eisu_pkg::MODE_FALL: raise[line_index] = prev && !pin_level;
            default:             raise[line_index] = !prev && pin_level;
          endcase
        end
      end
      eisu_pkg::REQ_TICK: begin
        for (int i = 0; i < 8; i++) begin
          raise[i] = line_en[i] && (modes[2*i +: 2] == eisu_pkg::MODE_LOW) && !line_levels[i];
        end
      end
      eisu_pkg::REQ_CONSUME: begin
        if (found_c) take[idx_c] = 1'b1;
      end
      default: ;
    endcase
    line_flags_next = (line_flags & ~take) | raise;
    {found_p, idx_p} = lowest(line_flags_next & line_mask_next & line_en);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sense_ctrl_low  <= 8'h00;
      sense_ctrl_high <= 8'h00;
      line_mask       <= 8'h00;
      line_flags      <= 8'h00;
      line_levels     <= 8'hff;
    end else if (cmd.load) begin
      sense_ctrl_low  <= sense_ctrl_low_next;
      sense_ctrl_high <= sense_ctrl_high_next;
      line_mask       <= line_mask_next;
      line_flags      <= line_flags_next;
      line_levels     <= line_levels_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rdata       <= rdata_next;
      irq_pending <= found_p;
      irq_line    <= idx_p;
      consumed    <= (req_type == eisu_pkg::REQ_CONSUME) && found_c;
      taken_line  <= ((req_type == eisu_pkg::REQ_CONSUME) && found_c) ? idx_c : 3'd0;
      adc_trigger <= raise[0];
    end
  end

endmodule

`default_nettype wire

>>> design/eisu_ctrl.sv
// handshake controller of the interrupt sense unit
// depends on eisu_pkg and the assertion macro header
`default_nettype none
`include "external_interrupt_sense_unit_top_macros.svh"

module eisu_ctrl (
  input  wire             clk,
  input  wire             rst,
  input  wire             in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire             out_ready,
  output eisu_pkg::cmd_t  cmd
);

  eisu_pkg::state_t state, state_next;

  always_comb begin
    state_next = state;
    case (state)
      eisu_pkg::ST_EMPTY: if (in_valid) state_next = eisu_pkg::ST_FULL;
      eisu_pkg::ST_FULL:  if (out_ready && !in_valid) state_next = eisu_pkg::ST_EMPTY;
      default:            state_next = eisu_pkg::ST_EMPTY;
    endcase
  end

  always_comb begin
    case (state)
      eisu_pkg::ST_EMPTY: begin
        in_ready  = 1'b1;
        out_valid = 1'b0;
      end
      eisu_pkg::ST_FULL: begin
        in_ready  = out_ready;
        out_valid = 1'b1;
      end
      default: begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
      end
    endcase
    cmd.load = in_valid && in_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= eisu_pkg::ST_EMPTY;
    else     state <= state_next;
  end

  `EISU_ASSERT_NOW(a_no_overwrite, out_valid && !out_ready, !cmd.load, "result overwritten")
  `EISU_ASSERT_NEXT(a_load_shows, cmd.load, out_valid, "loaded beat not presented")
  `EISU_ASSERT_NEXT(a_drain, out_valid && out_ready && !cmd.load, !out_valid, "beat repeated")

endmodule

`default_nettype wire

>>> design/external_interrupt_sense_unit_top.sv
// External interrupt sense unit, eight lines with level/edge sense,
// mask and flag registers, lowest-line request and consume.
//
// Input channel: in_valid/in_ready with req_type, reg_sel, wdata,
// line_index, pin_level. Output channel: out_valid/out_ready with rdata,
// irq_pending, irq_line, consumed, taken_line, adc_trigger.
// Every input beat gives exactly one output beat.
// Latency: the result is registered at the accepting edge and valid the
// next cycle. Throughput: one beat per cycle unless the output stalls;
// the whole step is one combinational pass over all lines into the
// state and result registers. A new beat is taken while a result is
// shown only in the cycle that result is taken, so a stalled receiver
// holds the input side too. Reset: sense controls, mask and flags
// clear, every line level reads high, no result pending.
// depends on eisu_pkg, eisu_ctrl, eisu_datapath
`default_nettype none

module external_interrupt_sense_unit_top #(
  parameter int LINES = 8
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire  [2:0] req_type,
  input  wire  [1:0] reg_sel,
  input  wire  [7:0] wdata,
  input  wire  [2:0] line_index,
  input  wire        pin_level,
  output logic       out_valid,
  input  wire        out_ready,
  output logic [7:0] rdata,
  output logic       irq_pending,
  output logic [2:0] irq_line,
  output logic       consumed,
  output logic [2:0] taken_line,
  output logic       adc_trigger
);

  eisu_pkg::cmd_t cmd;

  eisu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  eisu_datapath #(
    .LINES (LINES)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .req_type    (req_type),
    .reg_sel     (reg_sel),
    .wdata       (wdata),
    .line_index  (line_index),
    .pin_level   (pin_level),
    .rdata       (rdata),
    .irq_pending (irq_pending),
    .irq_line    (irq_line),
    .consumed    (consumed),
    .taken_line  (taken_line),
    .adc_trigger (adc_trigger)
  );

endmodule

`default_nettype wire
